/* rtl/call_return_tracer_macros.svh */
// assertion macros for the call/return tracer
// no dependencies; the using module must have clk and arst_n in scope
`ifndef CALL_RETURN_TRACER_MACROS_SVH
`define CALL_RETURN_TRACER_MACROS_SVH
`ifndef SYNTH
`define CRT_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("call_return_tracer: implication check failed");
`define CRT_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("call_return_tracer: next-cycle check failed");
`else
`define CRT_ASSERT_IMP(lbl, a, c)
`define CRT_ASSERT_NXT(lbl, a, c)
`endif
`endif

/* rtl/crt_pkg.sv */
// shared types, codes and constants of the call/return tracer
// no dependencies
`default_nettype none
package crt_pkg;

	localparam int SYMBOLS_DEFAULT   = 64;
	localparam int MAX_DEPTH_DEFAULT = 255;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_TRACE_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd1;

	// request types
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_TRACE = 1'b1;

	// event kinds
	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_CALL   = 2'd1;
	localparam logic [1:0] EV_RETURN = 2'd2;

	// instruction decode
	localparam logic [31:0] OPC_MASK       = 32'h0000_007F;
	localparam logic [31:0] OPC_JAL        = 32'h0000_006F;
	localparam logic [31:0] JALR_MASK      = 32'h0000_707F;
	localparam logic [31:0] OPC_JALR       = 32'h0000_0067;
	localparam logic [31:0] TARGET_ALIGN   = 32'hFFFF_FFFE;
	localparam logic [4:0]  REG_MASK       = 5'h1F;
	localparam logic [4:0]  REG_ZERO       = 5'd0;
	localparam logic [4:0]  REG_RA         = 5'd1;

	typedef struct packed {
		logic        req_type;
		logic [5:0]  entry_index;
		logic [31:0] func_start;
		logic [31:0] func_size;
		logic [31:0] pc;
		logic [31:0] instruction;
		logic [31:0] rs1_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [31:0] event_pc;
		logic [31:0] target_addr;
		logic [7:0]  call_depth;
		logic        symbol_found;
		logic [5:0]  symbol_index;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic scan_step;
		logic scan_latch;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic has_event;
		logic hit;
		logic exhausted;
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

endpackage
`default_nettype wire

/* rtl/call_return_tracer.sv */
// call/return tracer for retired rv32 instructions, top level
// depends on crt_pkg, crt_ctrl, crt_dp, crt_ram and call_return_tracer_macros.svh
//
// usage:
//   req channel (req_valid/req_ready/req) takes either a range-table load
//   (req_type 0) or a retired instruction to trace (req_type 1). every
//   request gives exactly one result on the rsp channel (rsp_valid/rsp_ready/rsp).
//   cfg_we/cfg_index/cfg_data write trace_enable (index 0) and symbol_count
//   (index 1); the user writes them only while the block is idle (not enforced).
//   one request is in work at a time. a load, a non-jump or a non-event jump goes
//   from accept to the finish state and on to the output register. a traced call
//   or return scans the range table one entry per cycle through the table ram's
//   single read port, at most min(symbol_count, SYMBOLS) entries, fewer on a hit.
//   reset clears the controller, the nesting depth and both registers; the
//   range table is not cleared and must be loaded before it is searched.
//   when rsp_ready is low the result holds in the output register and the
//   next request is still taken; its result waits until the register frees.
`default_nettype none
`include "call_return_tracer_macros.svh"
module call_return_tracer #(
	parameter int SYMBOLS   = crt_pkg::SYMBOLS_DEFAULT,
	parameter int MAX_DEPTH = crt_pkg::MAX_DEPTH_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [crt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [crt_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            req_valid,
	output logic                                 req_ready,
	input  wire crt_pkg::in_item_t               req,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_ready,
	output crt_pkg::out_item_t                   rsp
);
	import crt_pkg::*;

	cmd_t    cmd;
	status_t status;

	crt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status   (status),
		.cmd      (cmd)
	);

	crt_dp #(
		.SYMBOLS  (SYMBOLS),
		.MAX_DEPTH(MAX_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.cmd      (cmd),
		.status   (status),
		.rsp      (rsp)
	);

	// one request in work at a time
	`CRT_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
	// no-event results carry all-zero fields
	`CRT_ASSERT_IMP(a_none_zero, rsp_valid && rsp.event_kind == EV_NONE, rsp.event_pc == '0 && rsp.target_addr == '0 && rsp.call_depth == '0)
	`CRT_ASSERT_IMP(a_none_nosym, rsp_valid && !rsp.symbol_found, rsp.symbol_index == '0)

endmodule
`default_nettype wire

/* rtl/crt_ram.sv */
// generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none
module crt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/crt_ctrl.sv */
// controller of the call/return tracer: sequences accept, table scan and result hand-off
// depends on crt_pkg
`default_nettype none
module crt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	input  wire crt_pkg::status_t status,
	output crt_pkg::cmd_t         cmd
);
	import crt_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign out_free  = !out_valid_q || rsp_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.has_event ? ST_SCAN : ST_FIN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.hit || status.exhausted) begin
					cmd.scan_latch = 1'b1;
					state_d        = ST_FIN;
				end
			end
			ST_FIN: begin
				// result waits here until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/crt_dp.sv */
// datapath of the call/return tracer: decode, depth counter, range table and scan
// depends on crt_pkg and crt_ram
`default_nettype none
module crt_dp #(
	parameter int SYMBOLS   = crt_pkg::SYMBOLS_DEFAULT,
	parameter int MAX_DEPTH = crt_pkg::MAX_DEPTH_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [crt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [crt_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire crt_pkg::in_item_t               req,
	input  wire crt_pkg::cmd_t                   cmd,
	output crt_pkg::status_t                     status,
	output crt_pkg::out_item_t                   rsp
);
	import crt_pkg::*;

	localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
	localparam int CW = $clog2(SYMBOLS + 1);
	localparam int DW = $clog2(MAX_DEPTH + 1);

	// configuration
	logic                  trace_en_q;
	logic [CFG_DATA_W-1:0] sym_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_en_q  <= 1'b0;
			sym_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TRACE_ENABLE: trace_en_q  <= cfg_data[0];
				CFG_SYMBOL_COUNT: sym_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode of the incoming request
	logic [31:0]   inst;
	logic          is_jal, is_jalr;
	logic [4:0]    rd, rs1;
	logic [31:0]   imm_j, imm_i, target_d, look_d;
	logic [1:0]    kind_d;
	logic [DW-1:0] depth_q, depth_d, depth_rep;
	logic [31:0]   depth_w;
	out_item_t     res_init;

	always_comb begin
		inst    = req.instruction;
		is_jal  = (inst & OPC_MASK) == OPC_JAL;
		is_jalr = (inst & JALR_MASK) == OPC_JALR;
		rd      = inst[11:7] & REG_MASK;
		rs1     = inst[19:15] & REG_MASK;
		imm_j   = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
		imm_i   = {{20{inst[31]}}, inst[31:20]};
		target_d = is_jal ? (req.pc + imm_j) : ((req.rs1_value + imm_i) & TARGET_ALIGN);
		kind_d  = EV_NONE;
		if (req.req_type == REQ_TRACE && trace_en_q && (is_jal || is_jalr)) begin
			if (rd == REG_RA) begin
				kind_d = EV_CALL;
			end else if (rd == REG_ZERO && is_jalr && rs1 == REG_RA) begin
				kind_d = EV_RETURN;
			end
		end
		look_d    = (kind_d == EV_CALL) ? target_d : req.pc;
		depth_d   = depth_q;
		depth_rep = depth_q;
		case (kind_d)
			EV_CALL: begin
				if (depth_q < DW'(MAX_DEPTH)) begin
					depth_d = depth_q + 1'b1;
				end
			end
			EV_RETURN: begin
				if (depth_q != '0) begin
					depth_d = depth_q - 1'b1;
				end
				depth_rep = depth_d;
			end
			default: ;
		endcase
		depth_w = 32'(depth_rep);
		// symbol fields are filled in by the scan
		res_init = '0;
		if (kind_d != EV_NONE) begin
			res_init.event_kind  = kind_d;
			res_init.event_pc    = req.pc;
			res_init.target_addr = target_d;
			res_init.call_depth  = depth_w[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cmd.accept) begin
			depth_q <= depth_d;
		end
	end

	// range table, start in the upper half, size in the lower
	logic          tbl_we;
	logic [31:0]   slot_w;
	logic [63:0]   tbl_rdata;
	logic [CW-1:0] scan_addr_q;
	logic [CW-1:0] count_lim;

	assign slot_w = 32'(req.entry_index);
	assign tbl_we = cmd.accept && (req.req_type == REQ_LOAD) && (slot_w < SYMBOLS);

	crt_ram #(
		.WIDTH(64),
		.DEPTH(SYMBOLS)
	) u_tbl (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(slot_w[AW-1:0]),
		.wdata({req.func_start, req.func_size}),
		.raddr(scan_addr_q[AW-1:0]),
		.rdata(tbl_rdata)
	);

	// scan: issue one read a cycle, compare the entry that comes back
	logic          chk_valid_s1;
	logic [AW-1:0] chk_idx_s1;
	logic [31:0]   look_q;
	logic          issue, match;
	logic [31:0]   idx_w;

	assign count_lim = (32'(sym_count_q) > SYMBOLS) ? CW'(SYMBOLS) : CW'(sym_count_q);
	assign issue     = scan_addr_q < count_lim;
	assign match     = (look_q - tbl_rdata[63:32]) < tbl_rdata[31:0];
	assign idx_w     = 32'(chk_idx_s1);

	assign status.has_event = (kind_d != EV_NONE);
	assign status.hit       = chk_valid_s1 && match;
	assign status.exhausted = !chk_valid_s1 && !issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q  <= '0;
			chk_valid_s1 <= 1'b0;
		end else if (cmd.accept) begin
			scan_addr_q  <= '0;
			chk_valid_s1 <= 1'b0;
		end else if (cmd.scan_step) begin
			chk_valid_s1 <= issue;
			if (issue) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && issue) begin
			chk_idx_s1 <= scan_addr_q[AW-1:0];
		end
	end

	// result under construction and output register
	out_item_t res_q;
	out_item_t out_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			look_q <= look_d;
			res_q  <= res_init;
		end else if (cmd.scan_latch && status.hit) begin
			res_q.symbol_found <= 1'b1;
			res_q.symbol_index <= idx_w[5:0];
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp = out_q;

endmodule
`default_nettype wire
